// ===== src/led_matrix_pwm_row_scanner_unit_defines.svh =====
// Assertion macros shared by the LED matrix row scanner RTL.
`ifndef LED_MATRIX_PWM_ROW_SCANNER_UNIT_DEFINES_SVH
`define LED_MATRIX_PWM_ROW_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LMPRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LMPRS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lmprs_pkg.sv =====
// Shared types and constants of the LED matrix row scanner.
`timescale 1ns / 1ps
`default_nettype none
package lmprs_pkg;

  // Matrix geometry, set by the 4-bit row and column fields
  localparam int IDX_W  = 4;
  localparam int SIDE   = 1 << IDX_W;
  localparam int ADDR_W = 2 * IDX_W;
  localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(SIDE - 1);
  localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(SIDE - 1);

  // Pixel and PWM widths
  localparam int LVL_W   = 2;
  localparam int PX_W    = 2 * LVL_W;
  localparam int PHASE_W = 2;
  localparam int VAL_W   = 8;
  localparam int ACT_W   = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FIXED_MODE = 1'b0;
  localparam logic REG_FIXED_THR  = 1'b1;
  localparam logic [PHASE_W-1:0] FIXED_THR_RST = PHASE_W'(1);

  // Request action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_RESYNC = 2'd2
  } action_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Register contents
  typedef struct packed {
    logic               fixed_mode;
    logic [PHASE_W-1:0] fixed_threshold;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;
    logic resync;
    logic start;
    logic issue;
    logic advance;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic col_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== src/lmprs_if.sv =====
// Request and result channel interfaces of the LED matrix row scanner.
`timescale 1ns / 1ps
`default_nettype none
interface lmprs_in_if;
  logic                           valid;
  logic                           ready;
  logic [lmprs_pkg::ACT_W-1:0]    action;
  logic [lmprs_pkg::IDX_W-1:0]    pixel_row;
  logic [lmprs_pkg::IDX_W-1:0]    pixel_col;
  logic [lmprs_pkg::VAL_W-1:0]    pixel_value;

  modport source (output valid, action, pixel_row, pixel_col, pixel_value, input ready);
  modport sink   (input valid, action, pixel_row, pixel_col, pixel_value, output ready);
endinterface

interface lmprs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           red_on;
  logic                           green_on;
  logic [lmprs_pkg::IDX_W-1:0]    column_index;
  logic [lmprs_pkg::IDX_W-1:0]    scan_row;
  logic                           row_done;

  modport source (output valid, red_on, green_on, column_index, scan_row, row_done,
                  input ready);
  modport sink   (input valid, red_on, green_on, column_index, scan_row, row_done,
                  output ready);
endinterface
`default_nettype wire

// ===== src/lmprs_cfg_regs.sv =====
// APB register block: fixed mode and fixed threshold.
`timescale 1ns / 1ps
`default_nettype none
module lmprs_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lmprs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [lmprs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [lmprs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                     pready,
  output lmprs_pkg::cfg_t                          cfg
);

  logic                            fixed_mode_r;
  logic [lmprs_pkg::PHASE_W-1:0]   fixed_thr_r;
  logic                            wr_hit;
  logic                            reg_idx;

  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite;
  // word index: byte address / 4
  assign reg_idx = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_mode_r <= 1'b0;
      fixed_thr_r  <= lmprs_pkg::FIXED_THR_RST;
    end else if (wr_hit) begin
      unique case (reg_idx)
        lmprs_pkg::REG_FIXED_MODE: fixed_mode_r <= pwdata[0];
        lmprs_pkg::REG_FIXED_THR:  fixed_thr_r  <= pwdata[lmprs_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      lmprs_pkg::REG_FIXED_MODE:
        prdata = {{(lmprs_pkg::CFG_DATA_W-1){1'b0}}, fixed_mode_r};
      lmprs_pkg::REG_FIXED_THR:
        prdata = {{(lmprs_pkg::CFG_DATA_W-lmprs_pkg::PHASE_W){1'b0}}, fixed_thr_r};
      default:
        prdata = '0;
    endcase
  end

  assign cfg.fixed_mode      = fixed_mode_r;
  assign cfg.fixed_threshold = fixed_thr_r;

endmodule
`default_nettype wire

// ===== src/lmprs_ctrl.sv =====
// Controller: request decode, scan sequencing and result valid.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_pwm_row_scanner_unit_defines.svh"
module lmprs_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic [lmprs_pkg::ACT_W-1:0]       in_action,
  output logic                                   in_ready,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  input  wire lmprs_pkg::dp_sts_t                sts,
  output lmprs_pkg::dp_cmd_t                     cmd
);

  lmprs_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmprs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      lmprs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (lmprs_pkg::action_t'(in_action))
            lmprs_pkg::ACT_WRITE:  cmd.wr_en  = 1'b1;
            lmprs_pkg::ACT_RESYNC: cmd.resync = 1'b1;
            lmprs_pkg::ACT_TICK: begin
              cmd.start = 1'b1;
              state_nxt = lmprs_pkg::ST_SCAN;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      lmprs_pkg::ST_SCAN: begin
        // read next column when the result stage is free or being emptied
        cmd.issue = !out_valid_r || out_ready;
        if (cmd.issue && sts.col_last) begin
          cmd.advance = 1'b1;
          state_nxt   = lmprs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lmprs_pkg::ST_IDLE;
    endcase
  end

  // result stage fills on issue, drains on handshake
  always_comb begin
    if (cmd.issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // a pending result is never overwritten
  `LMPRS_ASSERT_IMP(a_no_overwrite, cmd.issue && out_valid_r, out_ready,
                    "result stage overwritten before it was taken")

endmodule
`default_nettype wire

// ===== src/lmprs_datapath.sv =====
// Datapath: frame store, row and phase counters, column scan and result stage.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_pwm_row_scanner_unit_defines.svh"
module lmprs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lmprs_pkg::cfg_t                   cfg,
  input  wire lmprs_pkg::dp_cmd_t                cmd,
  output lmprs_pkg::dp_sts_t                     sts,
  input  wire logic [lmprs_pkg::IDX_W-1:0]       pixel_row,
  input  wire logic [lmprs_pkg::IDX_W-1:0]       pixel_col,
  input  wire logic [lmprs_pkg::VAL_W-1:0]       pixel_value,
  output logic                                   red_on,
  output logic                                   green_on,
  output logic      [lmprs_pkg::IDX_W-1:0]       column_index,
  output logic      [lmprs_pkg::IDX_W-1:0]       scan_row,
  output logic                                   row_done
);

  localparam int DEPTH = lmprs_pkg::SIDE * lmprs_pkg::SIDE;

  // frame store and its per-entry valid bits
  logic [lmprs_pkg::PX_W-1:0]      mem [DEPTH];
  logic [DEPTH-1:0]                px_valid_r;
  logic [lmprs_pkg::ADDR_W-1:0]    waddr;
  logic [lmprs_pkg::ADDR_W-1:0]    raddr;
  logic [lmprs_pkg::PX_W-1:0]      wdata;

  // counters and scan context
  logic [lmprs_pkg::IDX_W-1:0]     row_counter_r;
  logic [lmprs_pkg::PHASE_W-1:0]   pwm_phase_r;
  logic [lmprs_pkg::IDX_W-1:0]     scan_row_r;
  logic [lmprs_pkg::PHASE_W-1:0]   scan_phase_r;
  logic [lmprs_pkg::IDX_W-1:0]     col_r;

  // result stage
  logic [lmprs_pkg::PX_W-1:0]      rd_px_r;
  logic                            rd_vld_r;
  logic [lmprs_pkg::PX_W-1:0]      px;
  logic [lmprs_pkg::IDX_W-1:0]     out_col_r;
  logic [lmprs_pkg::IDX_W-1:0]     out_row_r;
  logic [lmprs_pkg::PHASE_W-1:0]   out_phase_r;
  logic                            out_last_r;

  assign waddr = {pixel_row, pixel_col};
  // rotated read: store row = column, store column = SIDE-1-scan row
  assign raddr = {col_r, lmprs_pkg::ROW_LAST - scan_row_r};
  assign wdata = {pixel_value[5:4], pixel_value[1:0]};
  assign sts.col_last = (col_r == lmprs_pkg::COL_LAST);

  // store write
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_valid_r <= '0;
    end else if (cmd.wr_en) begin
      px_valid_r[waddr] <= 1'b1;
    end
  end

  // registered store read, loads the result stage
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_px_r     <= mem[raddr];
      rd_vld_r    <= px_valid_r[raddr];
      out_col_r   <= col_r;
      out_row_r   <= scan_row_r;
      out_phase_r <= scan_phase_r;
      out_last_r  <= sts.col_last;
    end
  end

  // scan context latched at tick start
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_row_r   <= row_counter_r;
      scan_phase_r <= cfg.fixed_mode ? cfg.fixed_threshold : pwm_phase_r;
    end
  end

  // column counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (cmd.start) begin
      col_r <= '0;
    end else if (cmd.issue) begin
      col_r <= col_r + 1'b1;
    end
  end

  // row counter and pwm phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_counter_r <= '0;
      pwm_phase_r   <= '0;
    end else if (cmd.resync) begin
      row_counter_r <= '0;
    end else if (cmd.advance) begin
      row_counter_r <= scan_row_r + 1'b1;
      if ((scan_row_r == lmprs_pkg::ROW_LAST) && !cfg.fixed_mode) begin
        pwm_phase_r <= pwm_phase_r + 1'b1;
      end
    end
  end

  // result fields: never-written entries read as zero
  assign px           = rd_vld_r ? rd_px_r : '0;
  assign red_on       = out_phase_r < px[lmprs_pkg::LVL_W-1:0];
  assign green_on     = out_phase_r < px[lmprs_pkg::PX_W-1:lmprs_pkg::LVL_W];
  assign column_index = out_col_r;
  assign scan_row     = out_row_r;
  assign row_done     = out_last_r;

  // a new scan starts from column zero
  `LMPRS_ASSERT_IMP(a_start_col_zero, cmd.start, col_r == '0,
                    "scan started with column counter not at zero")
  // row advance only with the last column read
  `LMPRS_ASSERT_IMP(a_advance_last, cmd.advance, cmd.issue && sts.col_last,
                    "row advanced away from the last column")
  // the row counter steps by one after a full row
  `LMPRS_ASSERT_NXT(a_row_step, cmd.advance,
                    row_counter_r == ($past(scan_row_r) + 1'b1),
                    "row counter did not step after a full row")

endmodule
`default_nettype wire

// ===== src/led_matrix_pwm_row_scanner_unit.sv =====
// Top level of the LED matrix PWM row scanner.
`timescale 1ns / 1ps
`default_nettype none
// Refresh engine for a 16 x 16 red/green LED matrix. Requests arrive on
// in_chan and are taken only while the block is idle. A refresh tick scans
// the row one column per cycle through the single read port of the frame
// store, as long as out_chan takes the results, and holds the request
// channel until the last column is read. Results leave on out_chan in
// column order; the last carries row_done. The image is rotated: scan row r,
// column c shows stored pixel (row c, column 15-r). A colour is lit when the
// PWM phase is below its 2-bit level; the phase steps modulo 4 after row 15
// unless fixed mode holds it at fixed_threshold. The frame store reads as all
// zero after reset with no clearing pass; registers are fixed_mode at byte 0
// and fixed_threshold at byte 4 on the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce.
module led_matrix_pwm_row_scanner_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  lmprs_in_if.sink                                 in_chan,
  lmprs_out_if.source                              out_chan,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lmprs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [lmprs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [lmprs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                     pready
);

  lmprs_pkg::cfg_t    cfg;
  lmprs_pkg::dp_cmd_t cmd;
  lmprs_pkg::dp_sts_t sts;

  // register block
  lmprs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // controller
  lmprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  lmprs_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_row    (in_chan.pixel_row),
    .pixel_col    (in_chan.pixel_col),
    .pixel_value  (in_chan.pixel_value),
    .red_on       (out_chan.red_on),
    .green_on     (out_chan.green_on),
    .column_index (out_chan.column_index),
    .scan_row     (out_chan.scan_row),
    .row_done     (out_chan.row_done)
  );

endmodule
`default_nettype wire

// ===== test/led_matrix_pwm_row_scanner_unit_tb.sv =====
// Self-checking testbench for the LED matrix PWM row scanner.
`timescale 1ns / 1ps
module led_matrix_pwm_row_scanner_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 24;
  // Action code outside the defined set, ignored by the block
  localparam logic [lmprs_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Byte addresses of the two registers
  localparam logic [lmprs_pkg::CFG_ADDR_W-1:0] ADDR_FIXED_MODE =
    {lmprs_pkg::REG_FIXED_MODE, 2'b00};
  localparam logic [lmprs_pkg::CFG_ADDR_W-1:0] ADDR_FIXED_THR  =
    {lmprs_pkg::REG_FIXED_THR, 2'b00};

  typedef struct packed {
    logic [lmprs_pkg::ACT_W-1:0] action;
    logic [lmprs_pkg::IDX_W-1:0] pixel_row;
    logic [lmprs_pkg::IDX_W-1:0] pixel_col;
    logic [lmprs_pkg::VAL_W-1:0] pixel_value;
  } pixel_req_t;

  typedef struct packed {
    logic                        red_on;
    logic                        green_on;
    logic [lmprs_pkg::IDX_W-1:0] column_index;
    logic [lmprs_pkg::IDX_W-1:0] scan_row;
    logic                        row_done;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite;
  logic [lmprs_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lmprs_pkg::CFG_DATA_W-1:0] pwdata;
  logic [lmprs_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  lmprs_in_if  in_chan ();
  lmprs_out_if out_chan ();

  led_matrix_pwm_row_scanner_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Shadow of the scanner state and registers
  logic [lmprs_pkg::PX_W-1:0]    pixel_shadow [lmprs_pkg::SIDE*lmprs_pkg::SIDE];
  logic [lmprs_pkg::IDX_W-1:0]   scan_row_q = '0;
  logic [lmprs_pkg::PHASE_W-1:0] pwm_phase_q = '0;
  logic                          fixed_mode_q = 1'b0;
  logic [lmprs_pkg::PHASE_W-1:0] fixed_thr_q = lmprs_pkg::FIXED_THR_RST;

  pixel_req_t pending_reqs[$];
  column_t    columns_due[$];

  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  int   n_writes = 0, n_ticks = 0, n_resyncs = 0, n_ignored = 0;
  int   n_columns = 0, n_cfg_writes = 0;

  initial begin
    foreach (pixel_shadow[i]) pixel_shadow[i] = '0;
  end

  task automatic note_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Update the shadow for one accepted request and queue the columns a tick yields
  task automatic apply_request(input pixel_req_t req);
    logic [lmprs_pkg::PHASE_W-1:0] phase_now;
    logic [lmprs_pkg::PX_W-1:0]    px;
    logic [lmprs_pkg::IDX_W-1:0]   c4;
    column_t                       col_res;
    case (req.action)
      lmprs_pkg::ACT_WRITE: begin
        pixel_shadow[{req.pixel_row, req.pixel_col}] =
          {req.pixel_value[5:4], req.pixel_value[1:0]};
        n_writes++;
      end
      lmprs_pkg::ACT_RESYNC: begin
        scan_row_q = '0;
        n_resyncs++;
      end
      lmprs_pkg::ACT_TICK: begin
        phase_now = fixed_mode_q ? fixed_thr_q : pwm_phase_q;
        // rotated read: scan row r, column c shows store row c, column SIDE-1-r
        for (int col = 0; col < lmprs_pkg::SIDE; col++) begin
          c4 = col[lmprs_pkg::IDX_W-1:0];
          px = pixel_shadow[{c4, ~scan_row_q}];
          col_res.red_on       = phase_now < px[lmprs_pkg::LVL_W-1:0];
          col_res.green_on     = phase_now < px[lmprs_pkg::PX_W-1:lmprs_pkg::LVL_W];
          col_res.column_index = c4;
          col_res.scan_row     = scan_row_q;
          col_res.row_done     = (c4 == lmprs_pkg::COL_LAST);
          columns_due.push_back(col_res);
        end
        if (scan_row_q == lmprs_pkg::ROW_LAST && !fixed_mode_q)
          pwm_phase_q = pwm_phase_q + 1'b1;
        scan_row_q = scan_row_q + 1'b1;
        n_ticks++;
      end
      default: n_ignored++;
    endcase
  endtask

  // Request driver: sends queued requests with random gaps unless tx_steady is set
  always @(posedge clk) begin : req_driver
    pixel_req_t nxt;
    pixel_req_t cur;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        cur = '{in_chan.action, in_chan.pixel_row, in_chan.pixel_col, in_chan.pixel_value};
        apply_request(cur);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_reqs.size() != 0 && (tx_steady || $urandom_range(99) >= 33)) begin
          nxt = pending_reqs.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.action      <= nxt.action;
          in_chan.pixel_row   <= nxt.pixel_row;
          in_chan.pixel_col   <= nxt.pixel_col;
          in_chan.pixel_value <= nxt.pixel_value;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each column against the oldest expectation
  always @(posedge clk) begin : col_monitor
    column_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        n_columns++;
        if (columns_due.size() == 0) begin
          note_mismatch($sformatf("unexpected column %0d row %0d",
                                  out_chan.column_index, out_chan.scan_row));
        end else begin
          want = columns_due.pop_front();
          if (out_chan.red_on !== want.red_on)
            note_mismatch($sformatf("red_on %b, want %b (row %0d col %0d)",
                                    out_chan.red_on, want.red_on, want.scan_row,
                                    want.column_index));
          if (out_chan.green_on !== want.green_on)
            note_mismatch($sformatf("green_on %b, want %b (row %0d col %0d)",
                                    out_chan.green_on, want.green_on, want.scan_row,
                                    want.column_index));
          if (out_chan.column_index !== want.column_index)
            note_mismatch($sformatf("column_index %0d, want %0d",
                                    out_chan.column_index, want.column_index));
          if (out_chan.scan_row !== want.scan_row)
            note_mismatch($sformatf("scan_row %0d, want %0d",
                                    out_chan.scan_row, want.scan_row));
          if (out_chan.row_done !== want.row_done)
            note_mismatch($sformatf("row_done %b, want %b (col %0d)",
                                    out_chan.row_done, want.row_done, want.column_index));
        end
      end
      out_chan.ready <= !hold_off && (rx_steady || $urandom_range(99) >= 33);
    end
  end

  // Long receiver hold-off so the block backs up into the request channel
  initial begin : rx_hold
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("led_matrix_pwm_row_scanner_unit verification failed");
      $finish;
    end
  end

  // APB write: setup then access; register takes the value on the access edge
  task automatic cfg_write(input logic [lmprs_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [1:0] val);
    logic [lmprs_pkg::CFG_DATA_W-1:0] data;
    data = $urandom();
    data[1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_FIXED_MODE) fixed_mode_q = data[0];
    else if (addr == ADDR_FIXED_THR) fixed_thr_q = data[lmprs_pkg::PHASE_W-1:0];
    n_cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every request is taken and every column is out, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_chan.valid || columns_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_req_t mk_req(input logic [lmprs_pkg::ACT_W-1:0] act,
                                        input logic [lmprs_pkg::IDX_W-1:0] row,
                                        input logic [lmprs_pkg::IDX_W-1:0] col,
                                        input logic [lmprs_pkg::VAL_W-1:0] val);
    pixel_req_t r;
    r = '{act, row, col, val};
    return r;
  endfunction

  // Random requests; ignored action codes do not count toward n
  task automatic queue_random(input int n, input int tick_pct);
    int         made;
    int         roll;
    pixel_req_t r;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(99);
      r.pixel_row   = lmprs_pkg::IDX_W'($urandom_range(lmprs_pkg::SIDE - 1));
      r.pixel_col   = lmprs_pkg::IDX_W'($urandom_range(lmprs_pkg::SIDE - 1));
      r.pixel_value = lmprs_pkg::VAL_W'($urandom_range(255));
      if (roll < tick_pct) r.action = lmprs_pkg::ACT_TICK;
      else if (roll < 95) r.action = lmprs_pkg::ACT_WRITE;
      else if (roll < 98) r.action = lmprs_pkg::ACT_RESYNC;
      else r.action = ACT_UNUSED;
      if (r.action != ACT_UNUSED) made++;
      pending_reqs.push_back(r);
    end
  endtask

  task automatic run_phase(input logic mode, input logic [1:0] thr,
                           input int n, input int tick_pct);
    cfg_write(ADDR_FIXED_MODE, {1'b0, mode});
    cfg_write(ADDR_FIXED_THR, thr);
    queue_random(n, tick_pct);
    settle();
  endtask

  initial begin : main_seq
    in_chan.valid       = 1'b0;
    in_chan.action      = lmprs_pkg::ACT_WRITE;
    in_chan.pixel_row   = '0;
    in_chan.pixel_col   = '0;
    in_chan.pixel_value = '0;
    out_chan.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, corner pixels, dropped value bits, ignored code, resync
    cfg_write(ADDR_FIXED_MODE, 2'd0);
    cfg_write(ADDR_FIXED_THR, 2'd1);
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_TICK, 4'd0, 4'd0, 8'h00));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_WRITE, 4'd0, 4'd15, 8'hFF));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_WRITE, 4'd15, 4'd15, 8'h33));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_WRITE, 4'd7, 4'd15, 8'h12));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_WRITE, 4'd3, 4'd15, 8'hCC));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_WRITE, 4'd15, 4'd14, 8'h21));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_WRITE, 4'd0, 4'd0, 8'h00));
    pending_reqs.push_back(mk_req(ACT_UNUSED, 4'd15, 4'd15, 8'hFF));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_RESYNC, 4'd0, 4'd0, 8'h00));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_TICK, 4'd15, 4'd15, 8'hFF));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_TICK, 4'd0, 4'd0, 8'h00));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_RESYNC, 4'd15, 4'd15, 8'hFF));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_TICK, 4'd0, 4'd0, 8'h00));
    pending_reqs.push_back(mk_req(ACT_UNUSED, 4'd0, 4'd0, 8'h00));
    pending_reqs.push_back(mk_req(lmprs_pkg::ACT_TICK, 4'd0, 4'd0, 8'h00));
    settle();

    // Random phases across register settings; outside fixed mode row wraps advance the PWM phase
    run_phase(1'b0, 2'd1, 90, 55);
    run_phase(1'b1, 2'd0, 40, 40);
    // receiver stalls long while the sender keeps pushing
    tx_steady = 1'b1;
    hold_go   = 1'b1;
    run_phase(1'b1, 2'd3, 40, 60);
    // stretch with no idling on either side
    rx_steady = 1'b1;
    run_phase(1'b1, 2'd2, 30, 40);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    run_phase(1'b0, 2'd0, 70, 50);

    if (columns_due.size() != 0)
      note_mismatch($sformatf("%0d columns never arrived", columns_due.size()));
    $display("Run covered %0d pixel writes, %0d ticks, %0d resyncs, %0d ignored codes",
             n_writes, n_ticks, n_resyncs, n_ignored);
    $display("%0d column results checked over %0d register writes, final PWM phase %0d",
             n_columns, n_cfg_writes, pwm_phase_q);
    if (mismatch_cnt == 0) begin
      $display("led_matrix_pwm_row_scanner_unit verification clean");
    end else begin
      $display("led_matrix_pwm_row_scanner_unit verification failed");
    end
    $finish;
  end

endmodule
